@@ rtl/mms_pkg.sv @@
// Package: widths, type codes, signatures and shared types of the content sniffer.
package mms_pkg;

    localparam int SNIFF_WINDOW = 512;
    localparam int HEAD_DEPTH   = 15;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CNT_W       = $clog2(SNIFF_WINDOW + 1);
    localparam int HEAD_IDX_W  = $clog2(HEAD_DEPTH);
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int THR_W       = 7;
    localparam int PROD_W      = CNT_W + THR_W + 1;

    localparam logic [THR_W-1:0] THR_RESET = 7'd95;
    localparam int               FULL_PCT  = 100;

    localparam int LEN_MIN_SIG  = 4;
    localparam int LEN_XML      = 5;
    localparam int LEN_HTML_TAG = 6;
    localparam int LEN_MP4      = 8;
    localparam int LEN_DOCTYPE  = 15;

    localparam logic [31:0] SIG_PNG     = 32'h474E5089;
    localparam logic [15:0] SIG_JPEG    = 16'hD8FF;
    localparam logic [31:0] SIG_GIF     = 32'h38464947;
    localparam logic [31:0] SIG_TIFF_LE = 32'h002A4949;
    localparam logic [31:0] SIG_TIFF_BE = 32'h2A004D4D;
    localparam logic [15:0] SIG_BMP     = 16'h4D42;
    localparam logic [31:0] SIG_ICON    = 32'h00010000;
    localparam logic [31:0] SIG_PDF     = 32'h46445025;
    localparam logic [31:0] SIG_ZIP     = 32'h04034B50;
    localparam logic [31:0] SIG_ZIP_EMP = 32'h06054B50;
    localparam logic [15:0] SIG_GZIP    = 16'h8B1F;
    localparam logic [31:0] SIG_RAR     = 32'h21726152;
    localparam logic [31:0] SIG_OGG     = 32'h5367674F;
    localparam logic [31:0] SIG_FLAC    = 32'h43614C66;
    localparam logic [15:0] SIG_MPEG_A  = 16'hFBFF;
    localparam logic [15:0] SIG_MPEG_B  = 16'hF3FF;

    localparam logic [31:0]  TAG_FTYP    = "ftyp";
    localparam logic [39:0]  TAG_XML     = "<?xml";
    localparam logic [111:0] TAG_DOCTYPE = "<!DOCTYPE html";
    localparam logic [39:0]  TAG_HTML    = "<html";

    typedef enum logic [4:0] {
        MIME_UNKNOWN = 5'd0,
        MIME_PNG     = 5'd1,
        MIME_JPEG    = 5'd2,
        MIME_GIF     = 5'd3,
        MIME_TIFF    = 5'd4,
        MIME_BMP     = 5'd5,
        MIME_ICON    = 5'd6,
        MIME_PDF     = 5'd7,
        MIME_ZIP     = 5'd8,
        MIME_GZIP    = 5'd9,
        MIME_RAR     = 5'd10,
        MIME_OGG     = 5'd11,
        MIME_FLAC    = 5'd12,
        MIME_MPEG    = 5'd13,
        MIME_MP4     = 5'd14,
        MIME_XML     = 5'd15,
        MIME_HTML    = 5'd16,
        MIME_TEXT    = 5'd17
    } t_mime_code;

    typedef struct packed {
        t_mime_code       sig;
        logic             try_text;
        logic [CNT_W-1:0] printable;
        logic [CNT_W-1:0] checked;
    } t_verdict;

endpackage

@@ rtl/mime_magic_sniffer_unit.sv @@
// Top level of the content-based file type sniffer.
//
//   channel  dir  handshake                     payload
//   s_axis   in   i_s_axis_tvalid/o_..._tready  tdata[7:0] data_byte, tlast last_byte
//   m_axis   out  o_m_axis_tvalid/i_..._tready  tdata[4:0] mime_code
//   cfg      in   i_cfg_we                      i_cfg_wdata[6:0] text_percent_threshold
//
// One byte beat per cycle; the front end only stalls when the verdict queue is full.
// A final byte's result reaches m_axis through the queue slot and the two back-end stages
// (products, then compare).
// Reset is synchronous: counters, head bytes and queue clear; threshold returns to 95.
// Output stalls back up into the four-entry queue before s_axis tready drops.
module mime_magic_sniffer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,  // [7:0] data_byte
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,  // [4:0] mime_code, [7:5] zero
    input  logic                      i_cfg_we,
    input  logic [mms_pkg::THR_W-1:0] i_cfg_wdata
);
    import mms_pkg::*;

    logic       space, push, q_valid, pop;
    t_verdict   front_rec, q_rec;
    t_mime_code code;

    mms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_space (space),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    mms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_space (space),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (pop)
    );

    mms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .o_code      (code),
        .i_ready     (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {3'b000, code};

endmodule

@@ rtl/mms_front.sv @@
// Front end: take byte beats, keep the file head and counters, classify signatures at end of file.
module mms_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output logic              o_ready,
    input  logic              i_space,
    output logic              o_push,
    output mms_pkg::t_verdict o_rec
);
    import mms_pkg::*;

    logic [7:0]       r_head [HEAD_DEPTH];
    logic [7:0]       n_head [HEAD_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_print, n_print;
    logic             accept;
    logic             is_print;
    logic [31:0]      w32;
    logic [15:0]      w16;
    t_mime_code       sig;
    logic             try_text;

    assign o_ready = i_space;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last;

    always_comb begin
        is_print = i_data inside {[8'd32:8'd126], 8'd9, 8'd10, 8'd13};
        n_head   = r_head;
        n_count  = r_count;
        n_print  = r_print;
        if (r_count < CNT_W'(SNIFF_WINDOW)) begin
            if (r_count < CNT_W'(HEAD_DEPTH)) begin
                n_head[r_count[HEAD_IDX_W-1:0]] = i_data;
            end
            if (is_print) begin
                n_print = r_print + 1'b1;
            end
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        w32      = {n_head[3], n_head[2], n_head[1], n_head[0]};
        w16      = w32[15:0];
        sig      = MIME_UNKNOWN;
        try_text = 1'b0;
        if (n_count < CNT_W'(LEN_MIN_SIG)) begin
            sig = MIME_UNKNOWN;
        end else if (w32 == SIG_PNG) begin
            sig = MIME_PNG;
        end else if (w16 == SIG_JPEG) begin
            sig = MIME_JPEG;
        end else if (w32 == SIG_GIF) begin
            sig = MIME_GIF;
        end else if (w32 == SIG_TIFF_LE || w32 == SIG_TIFF_BE) begin
            sig = MIME_TIFF;
        end else if (w16 == SIG_BMP) begin
            sig = MIME_BMP;
        end else if (w32 == SIG_ICON) begin
            sig = MIME_ICON;
        end else if (w32 == SIG_PDF) begin
            sig = MIME_PDF;
        end else if (w32 == SIG_ZIP || w32 == SIG_ZIP_EMP) begin
            sig = MIME_ZIP;
        end else if (w16 == SIG_GZIP) begin
            sig = MIME_GZIP;
        end else if (w32 == SIG_RAR) begin
            sig = MIME_RAR;
        end else if (w32 == SIG_OGG) begin
            sig = MIME_OGG;
        end else if (w32 == SIG_FLAC) begin
            sig = MIME_FLAC;
        end else if (w16 == SIG_MPEG_A || w16 == SIG_MPEG_B) begin
            sig = MIME_MPEG;
        end else if (n_count >= CNT_W'(LEN_MP4)
                     && {n_head[4], n_head[5], n_head[6], n_head[7]} == TAG_FTYP) begin
            sig = MIME_MP4;
        end else if (n_count >= CNT_W'(LEN_XML)
                     && {n_head[0], n_head[1], n_head[2], n_head[3], n_head[4]} == TAG_XML) begin
            sig = MIME_XML;
        end else if (n_count >= CNT_W'(LEN_DOCTYPE)
                     && {n_head[0], n_head[1], n_head[2], n_head[3], n_head[4], n_head[5],
                         n_head[6], n_head[7], n_head[8], n_head[9], n_head[10], n_head[11],
                         n_head[12], n_head[13]} == TAG_DOCTYPE) begin
            sig = MIME_HTML;
        end else if (n_count >= CNT_W'(LEN_HTML_TAG)
                     && {n_head[0], n_head[1], n_head[2], n_head[3], n_head[4]} == TAG_HTML) begin
            sig = MIME_HTML;
        end else begin
            try_text = 1'b1;
        end
        o_rec.sig       = sig;
        o_rec.try_text  = try_text;
        o_rec.printable = n_print;
        o_rec.checked   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_print <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                r_head[i] <= '0;
            end
        end else if (accept) begin
            if (i_last) begin
                r_count <= '0;
                r_print <= '0;
                for (int i = 0; i < HEAD_DEPTH; i++) begin
                    r_head[i] <= '0;
                end
            end else begin
                r_count <= n_count;
                r_print <= n_print;
                r_head  <= n_head;
            end
        end
    end

`ifndef SYNTH
    a_count_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SNIFF_WINDOW))
        else $error("byte count beyond window");
    a_print_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_print <= r_count)
        else $error("printable count exceeds byte count");
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_count == '0 && r_print == '0))
        else $error("counters not cleared after final beat");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_last && r_count < CNT_W'(SNIFF_WINDOW))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("byte count did not advance");
`endif

endmodule

@@ rtl/mms_fifo.sv @@
// Short queue of per-file verdict records between front and back end.
module mms_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mms_pkg::t_verdict i_rec,
    output logic              o_space,
    output logic              o_valid,
    output mms_pkg::t_verdict o_rec,
    input  logic              i_pop
);
    import mms_pkg::*;

    t_verdict               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_fill;
    logic                   do_push, do_pop;

    assign o_space = r_fill != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

@@ rtl/mms_back.sv @@
// Back end: threshold register, text percentage test and output register.
module mms_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mms_pkg::THR_W-1:0] i_cfg_wdata,
    input  logic                      i_q_valid,
    input  mms_pkg::t_verdict         i_q_rec,
    output logic                      o_pop,
    output logic                      o_valid,
    output mms_pkg::t_mime_code       o_code,
    input  logic                      i_ready
);
    import mms_pkg::*;

    logic [THR_W-1:0]  r_thresh;
    logic              r_a_valid, r_b_valid;
    t_mime_code        r_a_sig;
    logic              r_a_try;
    logic [PROD_W-1:0] r_lhs, r_rhs;
    logic [PROD_W-1:0] n_lhs, n_rhs;
    logic [THR_W:0]    thr_p1;
    t_mime_code        r_code, n_code;
    logic              a_ready, b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_pop   = i_q_valid && a_ready;
    assign o_valid = r_b_valid;
    assign o_code  = r_code;

    always_comb begin
        thr_p1 = {1'b0, r_thresh} + 1'b1;
        n_lhs  = PROD_W'(i_q_rec.printable) * PROD_W'(FULL_PCT);
        n_rhs  = PROD_W'(thr_p1) * PROD_W'(i_q_rec.checked);
        n_code = (r_a_try && r_lhs >= r_rhs) ? MIME_TEXT : r_a_sig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= THR_RESET;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_sig <= i_q_rec.sig;
            r_a_try <= i_q_rec.try_text;
            r_lhs   <= n_lhs;
            r_rhs   <= n_rhs;
        end
        if (b_ready && r_a_valid) begin
            r_code <= n_code;
        end
    end

endmodule
